@@ rtl/rtiu_pkg.sv @@
`default_nettype none

package rtiu_pkg;

    localparam int BANK_DEPTH     = 64;
    localparam int BANK_AW        = $clog2(BANK_DEPTH);
    localparam int BAD_LINE_STEAL = 40;

    // item opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [5:0] REG_CTRL1    = 6'h11;
    localparam logic [5:0] REG_RASTER   = 6'h12;
    localparam logic [5:0] REG_CTRL2    = 6'h16;
    localparam logic [5:0] REG_MEMPTR   = 6'h18;
    localparam logic [5:0] REG_IRQ_FLAG = 6'h19;
    localparam logic [5:0] REG_IRQ_EN   = 6'h1A;
    localparam logic [5:0] REG_COLL_SS  = 6'h1E;
    localparam logic [5:0] REG_COLL_SD  = 6'h1F;
    localparam logic [5:0] REG_COLOR0   = 6'h20;
    localparam logic [5:0] REG_COLOR1   = 6'h21;

    // raster thresholds
    localparam logic [8:0] LINE_DISP_FIRST = 9'h030;
    localparam logic [8:0] LINE_DISP_LAST  = 9'h0F7;
    localparam logic [8:0] LINE_TOP_25     = 9'h033;
    localparam logic [8:0] LINE_TOP_24     = 9'h037;
    localparam logic [8:0] LINE_BOT_25     = 9'h0FA;
    localparam logic [8:0] LINE_BOT_24     = 9'h0F6;

    localparam logic [6:0] RESET_CYCLES = 7'd63;

    // reset defaults of the bank
    localparam logic [7:0] RST_CTRL1    = 8'd27;
    localparam logic [7:0] RST_CTRL2    = 8'd200;
    localparam logic [7:0] RST_MEMPTR   = 8'd21;
    localparam logic [7:0] RST_IRQ_FLAG = 8'h70;
    localparam logic [7:0] RST_IRQ_EN   = 8'hF0;
    localparam logic [7:0] RST_COLOR0   = 8'hFE;
    localparam logic [7:0] RST_COLOR1   = 8'hF6;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [BANK_AW-1:0] addr;
        logic [7:0]         wdata;
    } t_bank_req;

    typedef struct packed {
        logic       irq;
        logic       started;
        logic       wrapped;
        logic       rd_hit;
        logic [7:0] rd_fixed;
    } t_rast_evt;

    typedef struct packed {
        logic [8:0] line;
        logic       bad;
        logic       border;
    } t_rast_state;

    function automatic logic [7:0] reset_value(input logic [BANK_AW-1:0] idx);
        logic [7:0] v;
        v = 8'd0;
        case (idx)
            REG_CTRL1:    v = RST_CTRL1;
            REG_CTRL2:    v = RST_CTRL2;
            REG_MEMPTR:   v = RST_MEMPTR;
            REG_IRQ_FLAG: v = RST_IRQ_FLAG;
            REG_IRQ_EN:   v = RST_IRQ_EN;
            REG_COLOR0:   v = RST_COLOR0;
            REG_COLOR1:   v = RST_COLOR1;
            default:      v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/raster_timing_irq_registers_unit.sv @@
// An accepted beat's result beat appears on the output register in the next cycle.
// Throughput: one beat per cycle unless the output stalls; the register bank memory
// has one read and one write port, and each item uses at most one access of each.
// Reset (synchronous, active low) clears the raster counters and control flops at once;
// bank entries keep reset defaults through per-entry written flags, so no clearing pass.
`default_nettype none

module raster_timing_irq_registers_unit
    import rtiu_pkg::*;
#(
    parameter int LINES_PER_FRAME = 312,
    parameter int CYCLES_PER_LINE = 63,
    parameter int NUM_REGS        = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [5:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_cpu_irq_masked,
    // output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_read_data,
    output logic            o_irq_request,
    output logic            o_line_started,
    output logic [8:0]      o_raster_line,
    output logic            o_bad_line,
    output logic            o_border_active,
    output logic            o_frame_done
);

    logic        accept;
    logic        idx_ok;
    logic        is_coll;
    t_rast_evt   evt;
    t_rast_state rstate;
    t_bank_req   bank_req;
    logic [7:0]  bank_rdata;
    logic [7:0]  or_mask;

    logic        r_out_vld;
    logic        r_use_mem;
    logic [7:0]  r_or_mask;
    logic [7:0]  r_fixed;
    logic        r_irq;
    logic        r_started;
    logic        r_wrapped;

    // Output register frees itself in the same cycle it is drained.
    assign o_stall = r_out_vld && i_stall;
    assign accept  = i_valid && !o_stall;

    assign idx_ok  = ({1'b0, i_reg_index} < 7'(NUM_REGS));
    assign is_coll = (i_reg_index == REG_COLL_SS) || (i_reg_index == REG_COLL_SD);

    // Raster counter and the control registers it consults live in flops;
    // it updates at the accepting edge, so its state always matches the
    // beat held in the output register.
    rtiu_raster #(
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .CYCLES_PER_LINE (CYCLES_PER_LINE)
    ) u_raster (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (accept),
        .i_opcode         (i_opcode),
        .i_reg_index      (i_reg_index),
        .i_write_data     (i_write_data),
        .i_cpu_irq_masked (i_cpu_irq_masked),
        .i_idx_ok         (idx_ok),
        .o_evt            (evt),
        .o_state          (rstate)
    );

    // Bank access: plain reads go to memory; collision registers are read
    // and cleared in one access (read-first port).
    always_comb begin
        bank_req.addr  = i_reg_index;
        bank_req.rd_en = accept && idx_ok && (i_opcode == OP_READ) && !evt.rd_hit;
        bank_req.wr_en = accept && idx_ok &&
                         ((i_opcode == OP_WRITE) || ((i_opcode == OP_READ) && is_coll));
        bank_req.wdata = (i_opcode == OP_WRITE) ? i_write_data : 8'd0;
    end

    rtiu_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bank_req),
        .o_rdata (bank_rdata)
    );

    // fixed bits forced on read
    always_comb begin
        or_mask = 8'd0;
        if (i_reg_index >= REG_COLOR0) begin
            or_mask = 8'hF0;
        end else if (i_reg_index == REG_CTRL2) begin
            or_mask = 8'hC0;
        end else if (i_reg_index == REG_MEMPTR) begin
            or_mask = 8'h01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_use_mem <= bank_req.rd_en;
            r_or_mask <= or_mask;
            r_fixed   <= evt.rd_hit ? evt.rd_fixed : 8'd0;
            r_irq     <= evt.irq;
            r_started <= evt.started;
            r_wrapped <= evt.wrapped;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_read_data     = r_use_mem ? (bank_rdata | r_or_mask) : r_fixed;
    assign o_irq_request   = r_irq;
    assign o_line_started  = r_started;
    assign o_frame_done    = r_wrapped;
    assign o_raster_line   = rstate.line;
    assign o_bad_line      = rstate.bad;
    assign o_border_active = rstate.border;

endmodule

`default_nettype wire

@@ rtl/rtiu_bank.sv @@
`default_nettype none

module rtiu_bank
    import rtiu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_bank_req i_req,
    output logic [7:0]     o_rdata
);

    logic [7:0]            r_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] r_vld;
    logic [7:0]            r_q;
    logic                  r_q_vld;
    logic [7:0]            r_q_rst;

    // read-first: a read-and-clear returns the old byte
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.addr];
        end
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q_vld <= r_vld[i_req.addr];
            r_q_rst <= reset_value(i_req.addr);
        end
    end

    // entries never written read as their reset default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    assign o_rdata = r_q_vld ? r_q : r_q_rst;

endmodule

`default_nettype wire

@@ rtl/rtiu_raster.sv @@
`default_nettype none

module rtiu_raster
    import rtiu_pkg::*;
#(
    parameter int LINES_PER_FRAME = 312,
    parameter int CYCLES_PER_LINE = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [1:0] i_opcode,
    input  wire logic [5:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_cpu_irq_masked,
    input  wire logic       i_idx_ok,
    output t_rast_evt       o_evt,
    output t_rast_state     o_state
);

    localparam logic [9:0] LPF      = 10'(LINES_PER_FRAME);
    localparam logic [6:0] CYC_FULL = 7'(CYCLES_PER_LINE);
    localparam logic [6:0] CYC_BAD  = 7'(CYCLES_PER_LINE - BAD_LINE_STEAL);

    logic [8:0] r_line, n_line;
    logic [6:0] r_cyc, n_cyc;
    logic       r_en, n_en;
    logic       r_bad, n_bad;
    logic       r_border, n_border;
    logic [8:0] r_irq_line, n_irq_line;
    logic       r_irq_vld, n_irq_vld;
    logic [7:0] r_ctrl1, n_ctrl1;
    logic [7:0] r_irq_flag, n_irq_flag;
    logic [7:0] r_irq_en, n_irq_en;

    logic [9:0] line_inc;
    logic       wrap;
    logic [8:0] nl;
    logic       den;
    logic       rsel;
    logic [8:0] top_line;
    logic [8:0] bot_line;

    assign line_inc = {1'b0, r_line} + 10'd1;
    assign wrap     = (line_inc >= LPF);
    assign nl       = wrap ? 9'd0 : line_inc[8:0];
    assign den      = r_ctrl1[4];
    assign rsel     = r_ctrl1[3];
    assign top_line = rsel ? LINE_TOP_25 : LINE_TOP_24;
    assign bot_line = rsel ? LINE_BOT_25 : LINE_BOT_24;

    always_comb begin
        n_line     = r_line;
        n_cyc      = r_cyc;
        n_en       = r_en;
        n_bad      = r_bad;
        n_border   = r_border;
        n_irq_line = r_irq_line;
        n_irq_vld  = r_irq_vld;
        n_ctrl1    = r_ctrl1;
        n_irq_flag = r_irq_flag;
        n_irq_en   = r_irq_en;
        o_evt      = '0;

        unique case (i_opcode)
            OP_TICK: begin
                if (r_cyc <= 7'd1) begin
                    o_evt.started = 1'b1;
                    o_evt.wrapped = wrap;
                    n_line        = nl;
                    if (nl == LINE_DISP_FIRST) begin
                        n_en = den;
                    end
                    n_bad = (nl >= LINE_DISP_FIRST) && (nl <= LINE_DISP_LAST) &&
                            (nl[2:0] == r_ctrl1[2:0]) && n_en;
                    if (nl == bot_line) begin
                        n_border = 1'b1;
                    end else if ((nl == top_line) && den) begin
                        n_border = 1'b0;
                    end
                    n_cyc = n_bad ? CYC_BAD : CYC_FULL;
                    if (r_irq_en[0] && r_irq_vld && (r_irq_line == nl) &&
                        !i_cpu_irq_masked) begin
                        o_evt.irq  = 1'b1;
                        n_irq_flag = r_irq_flag | 8'h81;
                    end
                end else begin
                    n_cyc = r_cyc - 7'd1;
                end
            end
            OP_WRITE: begin
                if (i_idx_ok) begin
                    unique case (i_reg_index)
                        REG_CTRL1: begin
                            n_ctrl1    = i_write_data;
                            n_irq_line = {i_write_data[7],
                                          r_irq_vld ? r_irq_line[7:0] : 8'd0};
                            n_irq_vld  = 1'b1;
                        end
                        REG_RASTER: begin
                            n_irq_line = {r_irq_vld ? r_irq_line[8] : 1'b0,
                                          i_write_data};
                            n_irq_vld  = 1'b1;
                        end
                        REG_IRQ_FLAG: n_irq_flag = i_write_data;
                        REG_IRQ_EN:   n_irq_en   = i_write_data;
                        default: ;
                    endcase
                end
            end
            OP_READ: begin
                if (i_idx_ok) begin
                    unique case (i_reg_index)
                        REG_CTRL1: begin
                            o_evt.rd_hit   = 1'b1;
                            o_evt.rd_fixed = {r_line[8], r_ctrl1[6:0]};
                        end
                        REG_RASTER: begin
                            o_evt.rd_hit   = 1'b1;
                            o_evt.rd_fixed = r_line[7:0];
                        end
                        REG_IRQ_FLAG: begin
                            o_evt.rd_hit   = 1'b1;
                            o_evt.rd_fixed = r_irq_flag | 8'h70;
                        end
                        REG_IRQ_EN: begin
                            o_evt.rd_hit   = 1'b1;
                            o_evt.rd_fixed = r_irq_en | 8'hF0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= 9'd0;
            r_cyc      <= RESET_CYCLES;
            r_en       <= 1'b0;
            r_bad      <= 1'b0;
            r_border   <= 1'b1;
            r_irq_line <= 9'd0;
            r_irq_vld  <= 1'b0;
            r_ctrl1    <= RST_CTRL1;
            r_irq_flag <= RST_IRQ_FLAG;
            r_irq_en   <= RST_IRQ_EN;
        end else if (i_take) begin
            r_line     <= n_line;
            r_cyc      <= n_cyc;
            r_en       <= n_en;
            r_bad      <= n_bad;
            r_border   <= n_border;
            r_irq_line <= n_irq_line;
            r_irq_vld  <= n_irq_vld;
            r_ctrl1    <= n_ctrl1;
            r_irq_flag <= n_irq_flag;
            r_irq_en   <= n_irq_en;
        end
    end

    assign o_state.line   = r_line;
    assign o_state.bad    = r_bad;
    assign o_state.border = r_border;

endmodule

`default_nettype wire

@@ sim/raster_timing_irq_registers_unit_checker.sv @@
`default_nettype none

module raster_timing_irq_registers_unit_checker
    import rtiu_pkg::*;
#(
    parameter int LINES_PER_FRAME = 312,
    parameter int CYCLES_PER_LINE = 63,
    parameter int NUM_REGS        = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel as seen at the block
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [5:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_cpu_irq_masked,
    // output channel as seen at the block
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_read_data,
    input  wire logic       i_irq_request,
    input  wire logic       i_line_started,
    input  wire logic [8:0] i_raster_line,
    input  wire logic       i_bad_line,
    input  wire logic       i_border_active,
    input  wire logic       i_frame_done,
    output int              o_mismatches,
    output int              o_pending
);

    localparam logic [8:0] FIRST_DISPLAY_LINE = 9'h030;
    localparam logic [8:0] LAST_DISPLAY_LINE  = 9'h0F7;
    localparam logic [8:0] TOP_LINE_25ROWS    = 9'h033;
    localparam logic [8:0] TOP_LINE_24ROWS    = 9'h037;
    localparam logic [8:0] BOTTOM_LINE_25ROWS = 9'h0FA;
    localparam logic [8:0] BOTTOM_LINE_24ROWS = 9'h0F6;
    localparam int         STOLEN_CYCLES      = 40;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       line_started;
        logic [8:0] raster_line;
        logic       bad_line;
        logic       border_active;
        logic       frame_done;
    } t_raster_report;

    logic [7:0]     bank [BANK_DEPTH];
    logic [8:0]     line_now;
    logic [8:0]     irq_target;
    logic           irq_target_set;
    int             cycles_left;
    logic           enable_latch;
    logic           bad_flag;
    logic           vborder;
    t_raster_report reports_due [$];

    task automatic restore_power_on_state();
        for (int i = 0; i < BANK_DEPTH; i++)
            bank[i] = 8'h00;
        bank[REG_CTRL1]    = 8'd27;
        bank[REG_CTRL2]    = 8'd200;
        bank[REG_MEMPTR]   = 8'd21;
        bank[REG_IRQ_FLAG] = 8'h70;
        bank[REG_IRQ_EN]   = 8'hF0;
        bank[REG_COLOR0]   = 8'hFE;
        bank[REG_COLOR1]   = 8'hF6;
        line_now       = '0;
        irq_target     = '0;
        irq_target_set = 1'b0;
        cycles_left    = 63;
        enable_latch   = 1'b0;
        bad_flag       = 1'b0;
        vborder        = 1'b1;
    endtask

    // new-line bookkeeping; returns 1 when the raster interrupt fires
    function automatic logic start_line(input logic masked);
        logic [7:0] ctrl;
        logic [8:0] top_line;
        logic [8:0] bottom_line;
        int         reload;
        logic       irq;
        ctrl        = bank[REG_CTRL1];
        top_line    = ctrl[3] ? TOP_LINE_25ROWS : TOP_LINE_24ROWS;
        bottom_line = ctrl[3] ? BOTTOM_LINE_25ROWS : BOTTOM_LINE_24ROWS;
        irq         = 1'b0;

        if (line_now == FIRST_DISPLAY_LINE)
            enable_latch = ctrl[4];
        bad_flag = line_now >= FIRST_DISPLAY_LINE && line_now <= LAST_DISPLAY_LINE &&
                   line_now[2:0] == ctrl[2:0] && enable_latch;

        if (line_now == bottom_line)
            vborder = 1'b1;
        else if (line_now == top_line && ctrl[4])
            vborder = 1'b0;

        reload = CYCLES_PER_LINE;
        if (bad_flag)
            reload = (reload > STOLEN_CYCLES) ? reload - STOLEN_CYCLES : 1;
        cycles_left = reload & 'h7F;
        if (cycles_left == 0)
            cycles_left = 1;

        if (bank[REG_IRQ_EN][0] && irq_target_set && irq_target == line_now && !masked) begin
            bank[REG_IRQ_FLAG] = bank[REG_IRQ_FLAG] | 8'h81;
            irq = 1'b1;
        end
        return irq;
    endfunction

    function automatic logic [7:0] read_register(input logic [5:0] idx);
        logic [7:0] v;
        if (int'(idx) >= NUM_REGS)
            return 8'h00;
        v = bank[idx];
        case (idx)
            REG_CTRL1:    v = {line_now[8], v[6:0]};
            REG_RASTER:   v = line_now[7:0];
            REG_CTRL2:    v = v | 8'hC0;
            REG_MEMPTR:   v = v | 8'h01;
            REG_IRQ_FLAG: v = v | 8'h70;
            REG_IRQ_EN:   v = v | 8'hF0;
            REG_COLL_SS, REG_COLL_SD: bank[idx] = 8'h00;  // clear on read
            default: ;
        endcase
        if (idx >= REG_COLOR0)
            v = v | 8'hF0;
        return v;
    endfunction

    function automatic void write_register(input logic [5:0] idx, input logic [7:0] val);
        if (int'(idx) >= NUM_REGS)
            return;
        if (idx == REG_CTRL1) begin
            if (!irq_target_set)
                irq_target = '0;
            irq_target     = {val[7], irq_target[7:0]};
            irq_target_set = 1'b1;
        end else if (idx == REG_RASTER) begin
            if (!irq_target_set)
                irq_target = '0;
            irq_target     = {irq_target[8], val};
            irq_target_set = 1'b1;
        end
        bank[idx] = val;
    endfunction

    function automatic t_raster_report next_report(input logic [1:0] op,
                                                   input logic [5:0] idx,
                                                   input logic [7:0] data,
                                                   input logic       masked);
        t_raster_report r;
        r = '0;
        case (op)
            OP_TICK: begin
                if (cycles_left <= 1) begin
                    r.line_started = 1'b1;
                    if (int'(line_now) + 1 >= LINES_PER_FRAME) begin
                        line_now     = '0;
                        r.frame_done = 1'b1;
                    end else begin
                        line_now = line_now + 9'd1;
                    end
                    r.irq_request = start_line(masked);
                end else begin
                    cycles_left--;
                end
            end
            OP_WRITE: write_register(idx, data);
            OP_READ:  r.read_data = read_register(idx);
            default: ;
        endcase
        r.raster_line   = line_now;
        r.bad_line      = bad_flag;
        r.border_active = vborder;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_raster_report want;
        if (!i_rst_n) begin
            restore_power_on_state();
            reports_due.delete();
        end else begin
            // result beat first: it always belongs to an older input beat
            if (i_out_valid && !i_out_stall) begin
                if (reports_due.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    o_mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("read_data", want.read_data, i_read_data);
                    check_field("irq_request", want.irq_request, i_irq_request);
                    check_field("line_started", want.line_started, i_line_started);
                    check_field("raster_line", want.raster_line, i_raster_line);
                    check_field("bad_line", want.bad_line, i_bad_line);
                    check_field("border_active", want.border_active, i_border_active);
                    check_field("frame_done", want.frame_done, i_frame_done);
                end
            end
            if (i_in_valid && !i_in_stall)
                reports_due.push_back(next_report(i_opcode, i_reg_index, i_write_data,
                                                  i_cpu_irq_masked));
        end
        o_pending = reports_due.size();
    end

endmodule

`default_nettype wire

@@ sim/raster_timing_irq_registers_unit_tb.sv @@
`default_nettype none

// Stimulus and verdict for the raster timing / interrupt register unit.
// Prediction and comparison live in the checker beside the DUT; this module
// only produces beats, paces both channels and decides pass or fail.
module raster_timing_irq_registers_unit_tb;
    import rtiu_pkg::*;

    localparam int         FRAME_LINES = 312;
    localparam int         LINE_CYCLES = 63;
    localparam int         REG_COUNT   = 64;
    // opcode 3 has no meaning; the block must treat it as a no-op
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    // total beats, directed ones included; four pacing phases across them
    localparam int         RANDOM_MIN  = 1400;
    localparam int         PHASE_BEATS = 344;
    localparam int         HOLD_CYCLES = 400;
    // ~1400 beats with idling and stalls in the slow phases, plus the long hold
    localparam int         CYCLE_LIMIT = 400000;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;

    // sender side
    logic       drv_valid      = 1'b0;
    logic [1:0] drv_opcode     = OP_TICK;
    logic [5:0] drv_reg_index  = '0;
    logic [7:0] drv_write_data = '0;
    logic       drv_masked     = 1'b0;
    int         src_idle_pct   = 0;

    // receiver side
    logic       sink_stall     = 1'b0;
    int         sink_stall_pct = 0;
    logic       hold_go        = 1'b0;
    logic       hold_done      = 1'b0;
    int         hold_left      = 0;

    // what the raster looked like on the last result beat; used to aim
    // the interrupt line a few lines ahead
    logic [8:0] seen_line      = '0;
    int         cycle_count    = 0;

    wire logic       o_stall;
    wire logic       o_valid;
    wire logic [7:0] o_read_data;
    wire logic       o_irq_request;
    wire logic       o_line_started;
    wire logic [8:0] o_raster_line;
    wire logic       o_bad_line;
    wire logic       o_border_active;
    wire logic       o_frame_done;
    int              mismatches;
    int              pending;

    always #4 clk = ~clk;

    raster_timing_irq_registers_unit #(
        .LINES_PER_FRAME (FRAME_LINES),
        .CYCLES_PER_LINE (LINE_CYCLES),
        .NUM_REGS        (REG_COUNT)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (drv_valid),
        .o_stall          (o_stall),
        .i_opcode         (drv_opcode),
        .i_reg_index      (drv_reg_index),
        .i_write_data     (drv_write_data),
        .i_cpu_irq_masked (drv_masked),
        .o_valid          (o_valid),
        .i_stall          (sink_stall),
        .o_read_data      (o_read_data),
        .o_irq_request    (o_irq_request),
        .o_line_started   (o_line_started),
        .o_raster_line    (o_raster_line),
        .o_bad_line       (o_bad_line),
        .o_border_active  (o_border_active),
        .o_frame_done     (o_frame_done)
    );

    raster_timing_irq_registers_unit_checker #(
        .LINES_PER_FRAME (FRAME_LINES),
        .CYCLES_PER_LINE (LINE_CYCLES),
        .NUM_REGS        (REG_COUNT)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (drv_valid),
        .i_in_stall       (o_stall),
        .i_opcode         (drv_opcode),
        .i_reg_index      (drv_reg_index),
        .i_write_data     (drv_write_data),
        .i_cpu_irq_masked (drv_masked),
        .i_out_valid      (o_valid),
        .i_out_stall      (sink_stall),
        .i_read_data      (o_read_data),
        .i_irq_request    (o_irq_request),
        .i_line_started   (o_line_started),
        .i_raster_line    (o_raster_line),
        .i_bad_line       (o_bad_line),
        .i_border_active  (o_border_active),
        .i_frame_done     (o_frame_done),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL raster_timing_irq_registers_unit");
            $finish;
        end
    end

    // Receiver: random stalls per the current phase, plus one long hold-off
    // counted here so the output register fills and the block stalls its input.
    always @(negedge clk) begin
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            sink_stall = 1'b1;
            hold_left--;
        end else begin
            sink_stall = ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Track the raster from accepted result beats.
    always @(posedge clk) begin
        if (rst_n && o_valid && !sink_stall) begin
            seen_line <= o_raster_line;
        end
    end

    // One input beat. Entered and left at a falling edge; valid stays high
    // between back-to-back beats and the payload holds while stalled.
    task automatic send_beat(input logic [1:0] op, input logic [5:0] idx,
                             input logic [7:0] data, input logic masked);
        while ($urandom_range(99) < src_idle_pct) begin
            drv_valid = 1'b0;
            @(negedge clk);
        end
        drv_valid      = 1'b1;
        drv_opcode     = op;
        drv_reg_index  = idx;
        drv_write_data = data;
        drv_masked     = masked;
        do
            @(posedge clk);
        while (o_stall);
        @(negedge clk);
    endtask

    // Registers with side effects or fixed read masks.
    function automatic logic [5:0] pick_special_reg(input int sel);
        case (sel)
            0:       return REG_CTRL1;
            1:       return REG_RASTER;
            2:       return REG_CTRL2;
            3:       return REG_MEMPTR;
            4:       return REG_IRQ_FLAG;
            5:       return REG_IRQ_EN;
            6:       return REG_COLL_SS;
            default: return REG_COLL_SD;
        endcase
    endfunction

    initial begin
        int         sent;
        int         next_phase_at;
        int         phase;
        int         r;
        logic [8:0] target;
        logic [5:0] idx;

        sent          = 0;
        phase         = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part, no idling ---
        // reset values through every read mask, then the top of the map
        send_beat(OP_READ,  REG_CTRL1,    8'h00, 1'b0);
        send_beat(OP_READ,  REG_RASTER,   8'h00, 1'b0);
        send_beat(OP_READ,  REG_CTRL2,    8'h00, 1'b0);
        send_beat(OP_READ,  REG_MEMPTR,   8'h00, 1'b0);
        send_beat(OP_READ,  REG_IRQ_FLAG, 8'h00, 1'b0);
        send_beat(OP_READ,  REG_IRQ_EN,   8'h00, 1'b0);
        send_beat(OP_READ,  REG_COLOR0,   8'h00, 1'b0);
        send_beat(OP_READ,  REG_COLOR1,   8'h00, 1'b0);
        send_beat(OP_READ,  6'h3F,        8'h00, 1'b0);
        // collision registers clear on read: second read must return zero
        send_beat(OP_WRITE, REG_COLL_SS,  8'hFF, 1'b0);
        send_beat(OP_READ,  REG_COLL_SS,  8'h00, 1'b0);
        send_beat(OP_READ,  REG_COLL_SS,  8'h00, 1'b0);
        send_beat(OP_WRITE, REG_COLL_SD,  8'hA5, 1'b0);
        send_beat(OP_READ,  REG_COLL_SD,  8'h00, 1'b0);
        // first control write while the irq line is still unset: low byte starts at zero
        send_beat(OP_WRITE, REG_CTRL1,    8'h9B, 1'b0);
        send_beat(OP_WRITE, REG_RASTER,   8'h00, 1'b0);
        send_beat(OP_WRITE, REG_IRQ_EN,   8'h01, 1'b0);
        send_beat(OP_READ,  REG_IRQ_EN,   8'h00, 1'b0);
        // unused opcode with every bit of the payload set
        send_beat(OP_UNUSED, 6'h3F,       8'hFF, 1'b1);
        send_beat(OP_WRITE, 6'h3F,        8'h00, 1'b0);
        send_beat(OP_READ,  6'h3F,        8'h00, 1'b0);
        send_beat(OP_WRITE, REG_CTRL2,    8'h00, 1'b0);
        send_beat(OP_READ,  REG_CTRL2,    8'h00, 1'b0);
        send_beat(OP_TICK,  6'h3F,        8'hFF, 1'b1);
        send_beat(OP_TICK,  6'h00,        8'h00, 1'b0);
        sent          = 25;
        next_phase_at = sent;

        // --- random part: mostly ticks so the raster keeps stepping lines ---
        while (sent < RANDOM_MIN) begin
            if (sent >= next_phase_at) begin
                // sender pause: let every pending result drain first
                drv_valid = 1'b0;
                wait (pending == 0);
                @(negedge clk);
                case (phase % 4)
                    0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                    1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
                    2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
                    default: begin src_idle_pct = 30; sink_stall_pct = 30; end
                endcase
                phase++;
                next_phase_at += PHASE_BEATS;
            end
            // long receiver hold-off while the sender keeps offering beats
            if (sent >= 300 && !hold_go)
                hold_go = 1'b1;

            r = $urandom_range(99);
            if (r < 86) begin
                // tick; index and data are don't-care but still toggle
                send_beat(OP_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)),
                          $urandom_range(99) < 25);
                sent++;
            end else if (r < 90) begin
                // aim the raster interrupt just ahead of the current line,
                // keep it mostly enabled and the display mostly on
                target = 9'((int'(seen_line) + $urandom_range(3)) % FRAME_LINES);
                send_beat(OP_WRITE, REG_IRQ_EN,
                          {7'($urandom_range(127)), 1'($urandom_range(99) < 80)}, 1'b0);
                send_beat(OP_WRITE, REG_CTRL1,
                          {target[8], 2'($urandom_range(3)), 1'($urandom_range(99) < 90),
                           1'($urandom_range(1)), 3'($urandom_range(7))},
                          1'($urandom_range(1)));
                send_beat(OP_WRITE, REG_RASTER, target[7:0], 1'($urandom_range(1)));
                sent += 3;
            end else if (r < 94) begin
                idx = $urandom_range(1) ? pick_special_reg($urandom_range(7))
                                        : 6'($urandom_range(63));
                // keep the display enable mostly set on plain control writes
                send_beat(OP_WRITE, idx,
                          (idx == REG_CTRL1) ? (8'($urandom_range(255)) | 8'h10)
                                             : 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                sent++;
            end else if (r < 99) begin
                idx = $urandom_range(1) ? pick_special_reg($urandom_range(7))
                                        : 6'($urandom_range(63));
                send_beat(OP_READ, idx, 8'($urandom_range(255)), 1'($urandom_range(1)));
                sent++;
            end else begin
                send_beat(OP_UNUSED, 6'($urandom_range(63)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                sent++;
            end
        end

        drv_valid = 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS raster_timing_irq_registers_unit");
        else
            $display("FAIL raster_timing_irq_registers_unit");
        $finish;
    end

endmodule

`default_nettype wire
